// ===== hdl/tgea_pkg.sv =====
// Package for the temporal graph earliest-arrival block.
// Holds sizes, operation and register codes, memory word layouts and the FSM type.
// No dependencies.
`default_nettype none

package tgea_pkg;

  localparam int unsigned NODES   = 1024;
  localparam int unsigned EDGES   = 4096;
  localparam int unsigned NODE_W  = 10;
  localparam int unsigned NCNT_W  = 11;
  localparam int unsigned EDGE_AW = 12;
  localparam int unsigned ECNT_W  = 13;
  localparam int unsigned TIME_W  = 30;
  localparam int unsigned CFG_W   = 11;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_XFER = 2'd1,
    OP_RUN  = 2'd2,
    OP_READ = 2'd3
  } op_e;

  typedef enum logic {
    CFG_NODE_COUNT = 1'b0,
    CFG_START_NODE = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_LD_WR,
    ST_XF_WR,
    ST_RD_WAIT,
    ST_RCLR,
    ST_SEED,
    ST_POP,
    ST_Q_WAIT,
    ST_U_WAIT,
    ST_E_RD,
    ST_E_WAIT,
    ST_V_WAIT,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic               head_vld;
    logic [EDGE_AW-1:0] head;
    logic [TIME_W-1:0]  xfer;
  } node_word_t;

  typedef struct packed {
    logic [TIME_W-1:0]  depart;
    logic [TIME_W-1:0]  arrive;
    logic [NODE_W-1:0]  dest;
    logic               next_vld;
    logic [EDGE_AW-1:0] next;
  } edge_word_t;

  typedef struct packed {
    logic [TIME_W-1:0] arrival;
    logic              reached;
    logic              queued;
  } run_word_t;

  typedef struct packed {
    logic [NODE_W-1:0] out_node;
    logic [TIME_W-1:0] arrival;
    logic              reached;
    logic              status;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/tgea_if.sv =====
// Valid/ready channel interfaces for items in and results out.
// Depends on tgea_pkg for field widths.
`default_nettype none

interface tgea_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    operation;
  logic [tgea_pkg::NODE_W-1:0]   node;
  logic [tgea_pkg::TIME_W-1:0]   depart_time;
  logic [tgea_pkg::NODE_W-1:0]   dest_node;
  logic [tgea_pkg::TIME_W-1:0]   arrive_time;
  logic [tgea_pkg::TIME_W-1:0]   transfer_time;

  modport source (output valid, operation, node, depart_time, dest_node, arrive_time,
                  transfer_time, input ready);
  modport sink (input valid, operation, node, depart_time, dest_node, arrive_time,
                transfer_time, output ready);
endinterface

interface tgea_out_if;
  logic                        valid;
  logic                        ready;
  logic [tgea_pkg::NODE_W-1:0] out_node;
  logic [tgea_pkg::TIME_W-1:0] arrival;
  logic                        reached;
  logic                        status;

  modport source (output valid, out_node, arrival, reached, status, input ready);
  modport sink (input valid, out_node, arrival, reached, status, output ready);
endinterface

`default_nettype wire

// ===== hdl/temporal_graph_earliest_arrival.sv =====
// Earliest-arrival search over timed connections, with a transfer time per node.
// A load passes a write state, a read a read-wait state (a refused load neither), then the
// result state; input ready again the cycle after, once the result register is free.
// A transfer load writes the node memory. A run clears the run memory, then pops each queued
// node and walks its connection list, reading the destination of each usable connection.
// Reset: clearing pass over node and run memories, no item accepted meanwhile.
`default_nettype none

module temporal_graph_earliest_arrival (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_idx_i,
  input  wire logic [tgea_pkg::CFG_W-1:0]   cfg_data_i,
  tgea_in_if.sink                           in_s,
  tgea_out_if.source                        out_s
);

  import tgea_pkg::*;

  // State and control registers
  state_e              state_q, state_d;
  logic [NCNT_W-1:0]   cnt_q, cnt_d;
  logic [NCNT_W-1:0]   node_count_q;
  logic [NODE_W-1:0]   start_q;
  logic [ECNT_W-1:0]   edge_used_q, edge_used_d;
  logic [NODE_W-1:0]   qhead_q, qhead_d;
  logic [NCNT_W-1:0]   qcnt_q, qcnt_d;
  logic                out_valid_q, out_valid_d;

  // Payload registers
  logic [1:0]          op_q, op_d;
  logic [NODE_W-1:0]   node_q, node_d;
  logic [TIME_W-1:0]   dep_q, dep_d;
  logic [NODE_W-1:0]   dst_q, dst_d;
  logic [TIME_W-1:0]   arr_q, arr_d;
  logic [TIME_W-1:0]   xfer_q, xfer_d;
  logic [NODE_W-1:0]   u_q, u_d;
  logic [TIME_W:0]     thr_q, thr_d;
  logic [EDGE_AW-1:0]  ptr_q, ptr_d;
  logic [TIME_W-1:0]   e_arr_q, e_arr_d;
  logic [NODE_W-1:0]   e_dst_q, e_dst_d;
  logic                e_nv_q, e_nv_d;
  logic [EDGE_AW-1:0]  e_next_q, e_next_d;
  res_t                res_q, res_d;
  res_t                out_q, out_d;

  // Memory ports
  logic                node_we, run_we, edge_we, q_we;
  logic [NODE_W-1:0]   node_addr, run_addr, q_addr;
  logic [EDGE_AW-1:0]  edge_addr;
  node_word_t          node_wd, node_rd;
  run_word_t           run_wd, run_rd;
  edge_word_t          edge_wd, edge_rd;
  logic [NODE_W-1:0]   q_wd, q_rd;

  // Helpers
  logic [NCNT_W-1:0]   n_act;
  logic                edges_full;
  logic                start_ok;
  logic                node_ok;
  logic                dst_ok;
  logic                cnt_last;
  logic                take;
  logic                out_free;
  logic [TIME_W:0]     thr_calc;
  logic                better;

  assign n_act      = (node_count_q > NCNT_W'(NODES)) ? NCNT_W'(NODES) : node_count_q;
  assign edges_full = (edge_used_q == ECNT_W'(EDGES));
  assign start_ok   = ({1'b0, start_q} < n_act);
  assign node_ok    = ({1'b0, node_q} < n_act);
  assign dst_ok     = ({1'b0, edge_rd.dest} < n_act);
  assign cnt_last   = (cnt_q == NCNT_W'(NODES - 1));
  assign take       = in_s.valid && in_s.ready;
  assign out_free   = !out_valid_q || out_s.ready;
  assign thr_calc   = {1'b0, run_rd.arrival} +
                      ((u_q == start_q) ? '0 : {1'b0, node_rd.xfer});
  assign better     = !run_rd.reached || (run_rd.arrival > e_arr_q);

  assign in_s.ready     = (state_q == ST_IDLE);
  assign out_s.valid    = out_valid_q;
  assign out_s.out_node = out_q.out_node;
  assign out_s.arrival  = out_q.arrival;
  assign out_s.reached  = out_q.reached;
  assign out_s.status   = out_q.status;

  tgea_ram #(.DATA_W($bits(node_word_t)), .DEPTH(NODES)) u_node_ram (
    .clk_i, .we_i(node_we), .addr_i(node_addr), .wdata_i(node_wd), .rdata_o(node_rd)
  );
  tgea_ram #(.DATA_W($bits(run_word_t)), .DEPTH(NODES)) u_run_ram (
    .clk_i, .we_i(run_we), .addr_i(run_addr), .wdata_i(run_wd), .rdata_o(run_rd)
  );
  tgea_ram #(.DATA_W($bits(edge_word_t)), .DEPTH(EDGES)) u_edge_ram (
    .clk_i, .we_i(edge_we), .addr_i(edge_addr), .wdata_i(edge_wd), .rdata_o(edge_rd)
  );
  tgea_ram #(.DATA_W(NODE_W), .DEPTH(NODES)) u_queue_ram (
    .clk_i, .we_i(q_we), .addr_i(q_addr), .wdata_i(q_wd), .rdata_o(q_rd)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLR:     if (cnt_last) state_d = ST_IDLE;
      ST_IDLE: begin
        if (take) begin
          unique case (op_e'(in_s.operation))
            OP_LOAD: state_d = edges_full ? ST_RESP : ST_LD_WR;
            OP_XFER: state_d = ST_XF_WR;
            OP_RUN:  state_d = ST_RCLR;
            OP_READ: state_d = ST_RD_WAIT;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_LD_WR:   state_d = ST_RESP;
      ST_XF_WR:   state_d = ST_IDLE;
      ST_RD_WAIT: state_d = ST_RESP;
      ST_RCLR:    if (cnt_last) state_d = start_ok ? ST_SEED : ST_IDLE;
      ST_SEED:    state_d = ST_POP;
      ST_POP:     state_d = (qcnt_q == '0) ? ST_IDLE : ST_Q_WAIT;
      ST_Q_WAIT:  state_d = ST_U_WAIT;
      ST_U_WAIT:  state_d = node_rd.head_vld ? ST_E_RD : ST_POP;
      ST_E_RD:    state_d = ST_E_WAIT;
      ST_E_WAIT: begin
        if (({1'b0, edge_rd.depart} >= thr_q) && dst_ok) state_d = ST_V_WAIT;
        else if (edge_rd.next_vld)                       state_d = ST_E_RD;
        else                                             state_d = ST_POP;
      end
      ST_V_WAIT:  state_d = e_nv_q ? ST_E_RD : ST_POP;
      ST_RESP:    if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    cnt_d       = cnt_q;
    edge_used_d = edge_used_q;
    qhead_d     = qhead_q;
    qcnt_d      = qcnt_q;
    op_d        = op_q;
    node_d      = node_q;
    dep_d       = dep_q;
    dst_d       = dst_q;
    arr_d       = arr_q;
    xfer_d      = xfer_q;
    u_d         = u_q;
    thr_d       = thr_q;
    ptr_d       = ptr_q;
    e_arr_d     = e_arr_q;
    e_dst_d     = e_dst_q;
    e_nv_d      = e_nv_q;
    e_next_d    = e_next_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    node_we   = 1'b0;
    node_addr = node_q;
    node_wd   = '0;
    run_we    = 1'b0;
    run_addr  = node_q;
    run_wd    = '0;
    edge_we   = 1'b0;
    edge_addr = ptr_q;
    edge_wd   = '0;
    q_we      = 1'b0;
    q_addr    = qhead_q;
    q_wd      = e_dst_q;

    // drop a delivered result
    if (out_valid_q && out_s.ready) out_valid_d = 1'b0;

    unique case (state_q)
      ST_CLR: begin
        node_we   = 1'b1;
        node_addr = cnt_q[NODE_W-1:0];
        run_we    = 1'b1;
        run_addr  = cnt_q[NODE_W-1:0];
        cnt_d     = cnt_last ? '0 : cnt_q + 1'b1;
      end
      ST_IDLE: begin
        node_addr = in_s.node;
        run_addr  = in_s.node;
        if (take) begin
          op_d   = in_s.operation;
          node_d = in_s.node;
          dep_d  = in_s.depart_time;
          dst_d  = in_s.dest_node;
          arr_d  = in_s.arrive_time;
          xfer_d = in_s.transfer_time;
          res_d  = '{out_node: in_s.node, arrival: '0, reached: 1'b0, status: 1'b1};
          cnt_d  = '0;
        end
      end
      ST_LD_WR: begin
        // push the connection onto the head of its source's list
        edge_we   = 1'b1;
        edge_addr = edge_used_q[EDGE_AW-1:0];
        edge_wd   = '{depart: dep_q, arrive: arr_q, dest: dst_q,
                      next_vld: node_rd.head_vld, next: node_rd.head};
        node_we   = 1'b1;
        node_wd   = '{head_vld: 1'b1, head: edge_used_q[EDGE_AW-1:0], xfer: node_rd.xfer};
        edge_used_d = edge_used_q + 1'b1;
        res_d     = '{out_node: node_q, arrival: '0, reached: 1'b0, status: 1'b0};
      end
      ST_XF_WR: begin
        node_we = 1'b1;
        node_wd = '{head_vld: node_rd.head_vld, head: node_rd.head, xfer: xfer_q};
      end
      ST_RD_WAIT: begin
        res_d = '{out_node: node_q,
                  arrival:  (node_ok && run_rd.reached) ? run_rd.arrival : '0,
                  reached:  node_ok && run_rd.reached,
                  status:   1'b0};
      end
      ST_RCLR: begin
        run_we   = 1'b1;
        run_addr = cnt_q[NODE_W-1:0];
        cnt_d    = cnt_last ? '0 : cnt_q + 1'b1;
      end
      ST_SEED: begin
        run_we   = 1'b1;
        run_addr = start_q;
        run_wd   = '{arrival: '0, reached: 1'b1, queued: 1'b1};
        q_we     = 1'b1;
        q_addr   = '0;
        q_wd     = start_q;
        qhead_d  = '0;
        qcnt_d   = NCNT_W'(1);
      end
      ST_POP: begin
        q_addr = qhead_q;
        if (qcnt_q != '0) begin
          qhead_d = qhead_q + 1'b1;
          qcnt_d  = qcnt_q - 1'b1;
        end
      end
      ST_Q_WAIT: begin
        u_d       = q_rd;
        run_addr  = q_rd;
        node_addr = q_rd;
      end
      ST_U_WAIT: begin
        // clear the in-queue mark and fix the departure threshold
        run_we   = 1'b1;
        run_addr = u_q;
        run_wd   = '{arrival: run_rd.arrival, reached: run_rd.reached, queued: 1'b0};
        thr_d    = thr_calc;
        ptr_d    = node_rd.head;
      end
      ST_E_RD: begin
        edge_addr = ptr_q;
      end
      ST_E_WAIT: begin
        e_arr_d  = edge_rd.arrive;
        e_dst_d  = edge_rd.dest;
        e_nv_d   = edge_rd.next_vld;
        e_next_d = edge_rd.next;
        run_addr = edge_rd.dest;
        ptr_d    = edge_rd.next;
      end
      ST_V_WAIT: begin
        run_addr = e_dst_q;
        if (better) begin
          run_we = 1'b1;
          run_wd = '{arrival: e_arr_q, reached: 1'b1, queued: 1'b1};
          if (!run_rd.queued) begin
            q_we   = 1'b1;
            q_addr = qhead_q + qcnt_q[NODE_W-1:0];
            q_wd   = e_dst_q;
            qcnt_d = qcnt_q + 1'b1;
          end
        end
        ptr_d = e_next_q;
      end
      ST_RESP: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLR;
      cnt_q        <= '0;
      node_count_q <= NCNT_W'(1);
      start_q      <= '0;
      edge_used_q  <= '0;
      qhead_q      <= '0;
      qcnt_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      edge_used_q <= edge_used_d;
      qhead_q     <= qhead_d;
      qcnt_q      <= qcnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_NODE_COUNT: node_count_q <= cfg_data_i;
          CFG_START_NODE: start_q      <= cfg_data_i[NODE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    node_q   <= node_d;
    dep_q    <= dep_d;
    dst_q    <= dst_d;
    arr_q    <= arr_d;
    xfer_q   <= xfer_d;
    u_q      <= u_d;
    thr_q    <= thr_d;
    ptr_q    <= ptr_d;
    e_arr_q  <= e_arr_d;
    e_dst_q  <= e_dst_d;
    e_nv_q   <= e_nv_d;
    e_next_q <= e_next_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  // Bounds, busy after take, valid seed; op_q is kept for the item in flight and checked on the load path
  a_qcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qcnt_q <= NCNT_W'(NODES)) else $error("work queue over capacity");
  a_edge_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_used_q <= ECNT_W'(EDGES)) else $error("connection store over capacity");
  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> state_q != ST_IDLE) else $error("item accepted without work");
  a_seed_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SEED |-> start_ok) else $error("seeding an unused start node");
  a_load_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LD_WR |-> op_q == OP_LOAD) else $error("load path without load item");

endmodule

`default_nettype wire

// ===== hdl/tgea_ram.sv =====
// Generic single-port synchronous RAM, read-first, with a registered read.
// No dependencies.
`default_nettype none

module tgea_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [DATA_W-1:0]        wdata_i,
  output      logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire
